// ===== design/dbgh_pkg.sv =====
// Shared types and constants for the bounce gap histogram block.
package dbgh_pkg;
	localparam int unsigned RowW = 3;
	localparam int unsigned BitsW = 16;
	localparam int unsigned TimeW = 16;
	localparam int unsigned BinW = 3;
	localparam int unsigned CountW = 8;
	localparam int unsigned NeedW = 4;
	localparam logic [CountW-1:0] CountMax = 8'd255;

	typedef enum logic {
		CMD_SCAN = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [RowW-1:0]   row;
		logic [BitsW-1:0]  raw_bits;
		logic [BitsW-1:0]  cooked_bits;
		logic [TimeW-1:0]  now_ms;
		logic [BinW-1:0]   bin_index;
	} req_t;
endpackage

// ===== design/debounce_bounce_gap_histogram.sv =====
// Top level of the key bounce gap histogram collector.
// A scan request walks the tracked columns once, each column taking a registered
// read of the per-key stores, then the raw and debounced update. A two-entry
// request queue lets the input side keep filling while the engine works, and the
// result register holds one answer for the consumer.
module debounce_bounce_gap_histogram #(
	parameter int unsigned ROWS = 8,
	parameter int unsigned COLS = 16,
	parameter int unsigned BUCKETS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata, // command, row, raw_bits, cooked_bits, now_ms, bin_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata  // bin_count, needed_debounce
);
	import dbgh_pkg::*;

	req_t in_req, q_req;
	logic q_valid, q_ready;
	logic [CountW-1:0] bin_count;
	logic [NeedW-1:0] needed_debounce;

	assign in_req.command = cmd_t'(s_tdata[0]);
	assign in_req.row = s_tdata[3:1];
	assign in_req.raw_bits = s_tdata[19:4];
	assign in_req.cooked_bits = s_tdata[35:20];
	assign in_req.now_ms = s_tdata[51:36];
	assign in_req.bin_index = s_tdata[54:52];
	assign m_tdata = {4'd0, needed_debounce, bin_count};

	dbgh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	dbgh_engine #(.ROWS(ROWS), .COLS(COLS), .BUCKETS(BUCKETS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.bin_count(bin_count), .needed_debounce(needed_debounce)
	);
endmodule

// ===== design/dbgh_front.sv =====
// Request intake and two-entry queue toward the engine.
module dbgh_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dbgh_pkg::req_t in_req,
	output logic           q_valid,
	input  logic           q_ready,
	output dbgh_pkg::req_t q_req
);
	import dbgh_pkg::*;

	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_req = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== design/dbgh_engine.sv =====
// Column-serial scan engine, histogram and result register.
module dbgh_engine #(
	parameter int unsigned ROWS = 8,
	parameter int unsigned COLS = 16,
	parameter int unsigned BUCKETS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  dbgh_pkg::req_t                q_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dbgh_pkg::CountW-1:0]   bin_count,
	output logic [dbgh_pkg::NeedW-1:0]    needed_debounce
);
	import dbgh_pkg::*;

	localparam int unsigned TCols = (COLS < 16) ? COLS : 16;
	localparam int unsigned ColW = (TCols > 1) ? $clog2(TCols) : 1;
	localparam int unsigned KeyW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
	localparam int unsigned BktW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned RIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CCntW = $clog2(TCols + 1);
	localparam int unsigned HiW = $clog2(BUCKETS + 1);
	localparam logic [BitsW-1:0] Mask = BitsW'((17'd1 << TCols) - 17'd1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RAW,
		ST_FIN
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [CCntW-1:0] col_q;
	logic phase_q;
	logic [RIdxW-1:0] ridx;
	logic [KeyW-1:0] key;
	logic [TimeW-1:0] ctime_q [ROWS*COLS];
	logic [CountW-1:0] gap_q [ROWS*COLS];
	logic [ROWS*COLS-1:0] gvld_q;
	logic [TimeW-1:0] ctime_rd_q;
	logic [CountW-1:0] gap_rd_q;
	logic [BitsW-1:0] praw_q [ROWS];
	logic [BitsW-1:0] pck_q [ROWS];
	logic [BitsW-1:0] open_q [ROWS];
	logic [BitsW-1:0] stab_q [ROWS];
	logic [CountW-1:0] hist_q [BUCKETS];
	logic [BitsW-1:0] rchg_q, kchg_q;
	logic [ColW-1:0] col;
	logic [TimeW-1:0] gap16;
	logic [CountW-1:0] gap_sat, gap_cur, gap_new;
	logic open_bit, open_nxt, wr_en;
	logic [CountW:0] need;
	logic [HiW-1:0] top, hi;
	logic [BitsW-1:0] stable, now_stab;
	logic [CountW-1:0] rd_cnt;
	logic row_ok;

	assign ridx = q_req.row[RIdxW-1:0];
	assign row_ok = {29'd0, req_q.row} < ROWS;
	assign col = col_q[ColW-1:0];
	assign key = KeyW'(req_q.row) * KeyW'(COLS) + KeyW'(col);
	assign gap16 = req_q.now_ms - ctime_rd_q;
	assign gap_sat = (gap16 > 16'd255) ? CountMax : gap16[CountW-1:0];
	assign gap_cur = gvld_q[key] ? gap_rd_q : '0;
	assign open_bit = open_q[req_q.row[RIdxW-1:0]][col];
	assign gap_new = !rchg_q[col] ? gap_cur
		: (!open_bit ? '0 : ((gap_sat > gap_cur) ? gap_sat : gap_cur));
	assign open_nxt = (open_bit | rchg_q[col]) & ~kchg_q[col];
	assign wr_en = (state_q == ST_RAW) && phase_q && rchg_q[col];
	assign need = {1'b0, gap_new} + 9'd1;
	assign top = (need < 9'(BUCKETS)) ? HiW'(need) : HiW'(BUCKETS);
	assign stable = ~(req_q.raw_bits ^ pck_q[req_q.row[RIdxW-1:0]]) & Mask;
	assign now_stab = open_q[req_q.row[RIdxW-1:0]] & stable;
	assign q_ready = (state_q == ST_IDLE) && !out_valid;
	assign rd_cnt = ({29'd0, q_req.bin_index} < BUCKETS) ? hist_q[q_req.bin_index[BktW-1:0]]
		: '0;

	always_comb begin
		hi = HiW'(1);
		for (int i = 0; i < BUCKETS; i++)
			if (hist_q[i] != '0) hi = HiW'(i + 1);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctime_q[key] <= req_q.now_ms;
			gap_q[key] <= gap_new;
		end
		ctime_rd_q <= ctime_q[key];
		gap_rd_q <= gap_q[key];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			bin_count <= '0;
			needed_debounce <= '0;
			col_q <= '0;
			phase_q <= 1'b0;
			rchg_q <= '0;
			kchg_q <= '0;
			req_q <= '0;
			gvld_q <= '0;
			for (int i = 0; i < ROWS; i++) begin
				praw_q[i] <= '0;
				pck_q[i] <= '0;
				open_q[i] <= '0;
				stab_q[i] <= '0;
			end
			for (int i = 0; i < BUCKETS; i++) hist_q[i] <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						req_q <= q_req;
						col_q <= '0;
						phase_q <= 1'b0;
						if (q_req.command == CMD_READ) begin
							bin_count <= rd_cnt;
							needed_debounce <= NeedW'(hi);
							out_valid <= 1'b1;
						end else if ({29'd0, q_req.row} < ROWS) begin
							rchg_q <= (praw_q[ridx] ^ q_req.raw_bits) & Mask;
							kchg_q <= (pck_q[ridx] ^ q_req.cooked_bits) & Mask;
							state_q <= ST_RAW;
						end else begin
							bin_count <= '0;
							needed_debounce <= NeedW'(hi);
							out_valid <= 1'b1;
						end
					end
				end
				ST_RAW: begin
					if (!phase_q) phase_q <= 1'b1;
					else begin
						phase_q <= 1'b0;
						open_q[req_q.row[RIdxW-1:0]][col] <= open_nxt;
						if (wr_en) gvld_q[key] <= 1'b1;
						if (kchg_q[col] && gap_new != '0)
							for (int t = 0; t < BUCKETS; t++)
								if (HiW'(t) < top && hist_q[t] != CountMax)
									hist_q[t] <= hist_q[t] + 1'b1;
						if (col_q == CCntW'(TCols - 1)) begin
							praw_q[req_q.row[RIdxW-1:0]] <= req_q.raw_bits;
							state_q <= ST_FIN;
						end else col_q <= col_q + 1'b1;
					end
				end
				ST_FIN: begin
					open_q[req_q.row[RIdxW-1:0]] <= open_q[req_q.row[RIdxW-1:0]]
						& ~(stab_q[req_q.row[RIdxW-1:0]] & now_stab);
					stab_q[req_q.row[RIdxW-1:0]] <= now_stab;
					pck_q[req_q.row[RIdxW-1:0]] <= req_q.cooked_bits;
					bin_count <= '0;
					needed_debounce <= NeedW'(hi);
					out_valid <= row_ok;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the key bounce gap histogram collector.
module tb;
	import dbgh_pkg::*;

	localparam int NROWS = 8;
	localparam int NCOLS = 16;
	localparam int NBINS = 8;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;

	debounce_bounce_gap_histogram DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [CountW-1:0] bin_count;
		logic [NeedW-1:0]  needed;
	} answer_t;

	logic [TimeW-1:0]  key_change_ms [NROWS*NCOLS];
	logic [7:0]        key_gap [NROWS*NCOLS];
	logic [BitsW-1:0]  prior_raw [NROWS];
	logic [BitsW-1:0]  last_cooked [NROWS];
	logic [BitsW-1:0]  bouncing [NROWS];
	logic [BitsW-1:0]  idle_once [NROWS];
	logic [CountW-1:0] hist [NBINS];
	logic [TimeW-1:0]  clock_ms [NROWS];

	answer_t pending_answers [$];
	int mismatches;
	int answers_seen;
	int scans_sent;
	int reads_sent;
	bit idle_enable;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb failed");
		$finish;
	end

	function automatic logic [NeedW-1:0] debounce_estimate();
		int hi;
		hi = 0;
		for (int i = 0; i < NBINS; i++)
			if (hist[i] != 0)
				hi = i;
		return NeedW'((hi + 1 > NBINS) ? NBINS : hi + 1);
	endfunction

	function automatic answer_t predict_answer(req_t rq);
		answer_t a;
		logic [BitsW-1:0] rchg, cchg, steady, now_steady;
		logic [TimeW-1:0] gap;
		int k, top, r;
		a.bin_count = '0;
		r = rq.row;
		if (rq.command == CMD_SCAN) begin
			rchg = prior_raw[r] ^ rq.raw_bits;
			cchg = last_cooked[r] ^ rq.cooked_bits;
			for (int c = 0; c < NCOLS; c++) begin
				k = r * NCOLS + c;
				if (rchg[c]) begin
					if (bouncing[r][c]) begin
						gap = rq.now_ms - key_change_ms[k];
						if (gap > key_gap[k])
							key_gap[k] = (gap <= 255) ? gap[7:0] : 8'd255;
					end else begin
						bouncing[r][c] = 1'b1;
						key_gap[k] = 0;
					end
					key_change_ms[k] = rq.now_ms;
				end
			end
			prior_raw[r] = rq.raw_bits;
			for (int c = 0; c < NCOLS; c++) begin
				k = r * NCOLS + c;
				if (cchg[c]) begin
					if (key_gap[k] > 0) begin
						top = (key_gap[k] + 1 < NBINS) ? key_gap[k] + 1 : NBINS;
						for (int t = 0; t < top; t++)
							if (hist[t] != CountMax)
								hist[t]++;
					end
					bouncing[r][c] = 1'b0;
				end
			end
			steady = ~(rq.raw_bits ^ last_cooked[r]);
			now_steady = bouncing[r] & steady;
			bouncing[r] = bouncing[r] & ~(idle_once[r] & now_steady);
			idle_once[r] = now_steady;
			last_cooked[r] = rq.cooked_bits;
		end else begin
			a.bin_count = hist[rq.bin_index];
		end
		a.needed = debounce_estimate();
		return a;
	endfunction

	task automatic send_request(req_t rq);
		while (idle_enable && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {rq.bin_index, rq.now_ms, rq.cooked_bits, rq.raw_bits, rq.row, rq.command};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pending_answers.push_back(predict_answer(rq));
		if (rq.command == CMD_SCAN)
			scans_sent++;
		else
			reads_sent++;
		@(negedge clk);
	endtask

	task automatic scan(int r, logic [15:0] raw, logic [15:0] cooked, logic [15:0] t);
		req_t rq;
		rq = '{CMD_SCAN, r[2:0], raw, cooked, t, 3'($urandom)};
		send_request(rq);
	endtask

	task automatic read_bin(int b);
		req_t rq;
		rq = '{CMD_READ, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), b[2:0]};
		send_request(rq);
	endtask

	always @(negedge clk)
		m_tready <= !idle_enable || ($urandom_range(99) >= 17);

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer %h", m_tdata);
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[7:0] !== want.bin_count || m_tdata[11:8] !== want.needed
						|| m_tdata[15:12] !== 4'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want count %0d need %0d, got %h",
							want.bin_count, want.needed, m_tdata);
				end
			end
		end
	end

	task automatic test_extremes();
		scan(0, 16'hFFFF, 16'h0000, 16'h0000);
		scan(0, 16'h0000, 16'h0000, 16'hFFFF);
		scan(0, 16'hFFFF, 16'hFFFF, 16'h0004);
		scan(7, 16'h0001, 16'h0000, 16'd10);
		scan(7, 16'h0000, 16'h0000, 16'd400);
		scan(7, 16'h0001, 16'h0001, 16'd401);
		scan(7, 16'h0001, 16'h0001, 16'd402);
		scan(7, 16'h0001, 16'h0001, 16'd403);
		scan(3, 16'h8000, 16'h0000, 16'd50);
		scan(3, 16'h8000, 16'h0000, 16'd51);
		scan(3, 16'h8000, 16'h0000, 16'd52);
		scan(3, 16'h0000, 16'h0000, 16'd53);
		for (int b = 0; b < NBINS; b++)
			read_bin(b);
	endtask

	task automatic test_bounce_events();
		int r, c;
		logic [15:0] t, raw, cooked;
		for (int n = 0; n < 220; n++) begin
			r = $urandom_range(NROWS - 1);
			c = $urandom_range(NCOLS - 1);
			t = clock_ms[r];
			raw = prior_raw[r];
			cooked = last_cooked[r];
			for (int b = $urandom_range(3, 1); b > 0; b--) begin
				raw[c] = ~raw[c];
				t += $urandom_range(9, 1);
				scan(r, raw, cooked, t);
			end
			if (raw[c] == cooked[c]) begin
				raw[c] = ~raw[c];
				t += $urandom_range(4, 1);
				scan(r, raw, cooked, t);
			end
			cooked[c] = raw[c];
			t += $urandom_range(3, 1);
			scan(r, raw, cooked, t);
			if ($urandom_range(3) == 0)
				read_bin($urandom_range(NBINS - 1));
			clock_ms[r] = t;
		end
	endtask

	task automatic test_random_noise();
		for (int n = 0; n < 350; n++) begin
			if ($urandom_range(4) == 0)
				read_bin($urandom_range(NBINS - 1));
			else
				scan($urandom_range(NROWS - 1), 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata = 0;
		idle_enable = 0;
		mismatches = 0;
		answers_seen = 0;
		scans_sent = 0;
		reads_sent = 0;
		for (int i = 0; i < NROWS * NCOLS; i++) begin
			key_change_ms[i] = 0;
			key_gap[i] = 0;
		end
		for (int i = 0; i < NROWS; i++) begin
			prior_raw[i] = 0;
			last_cooked[i] = 0;
			bouncing[i] = 0;
			idle_once[i] = 0;
			clock_ms[i] = 0;
		end
		for (int i = 0; i < NBINS; i++)
			hist[i] = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_extremes();
		test_bounce_events();
		idle_enable = 1;
		test_bounce_events();
		test_random_noise();
		for (int b = 0; b < NBINS; b++)
			read_bin(b);
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d row scans and %0d bin reads, checked %0d answers",
			scans_sent, reads_sent, answers_seen);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb failed");
		end
		$finish;
	end
endmodule

// ===== debounce_bounce_gap_histogram.f =====
design/dbgh_pkg.sv
design/dbgh_front.sv
design/dbgh_engine.sv
design/debounce_bounce_gap_histogram.sv
test/tb.sv
